FILE: rtl/dpb_pkg.sv
// Package with shared types, constants and helpers for the depth back-projection block.
package dpb_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_INV_SCALE     = 3'd2;
	localparam logic [2:0] REG_PRINCIPAL_X   = 3'd3;
	localparam logic [2:0] REG_PRINCIPAL_Y   = 3'd4;
	localparam logic [2:0] REG_INV_FOCAL_X   = 3'd5;
	localparam logic [2:0] REG_INV_FOCAL_Y   = 3'd6;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	// Field widths.
	localparam int SIZE_REG_W  = 13;
	localparam int SIZE_CMP_W  = 14;
	localparam int COEF_W      = 24;
	localparam int CENTRE_W    = 16;
	localparam int DEPTH_W     = 16;
	localparam int COLOUR_W    = 8;
	localparam int Z_FULL_W    = 32;
	localparam int Z_W         = 23;
	localparam int POINT_W     = 32;
	localparam int PIX_W       = 12;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 136;

	// Reset values of the configuration registers.
	localparam logic [SIZE_REG_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
	localparam logic [SIZE_REG_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
	localparam logic [COEF_W-1:0]     RST_INV_SCALE    = 24'd16777;
	localparam logic [CENTRE_W-1:0]   RST_PRINCIPAL_X  = 16'd5112;
	localparam logic [CENTRE_W-1:0]   RST_PRINCIPAL_Y  = 16'd3832;
	localparam logic [COEF_W-1:0]     RST_INV_FOCAL    = 24'd31957;

	// Valid depth window in Q16 metres: above 0.1 m, up to 100 m.
	localparam logic [Z_FULL_W-1:0] Z_MIN_Q16 = 32'd6553;
	localparam logic [Z_FULL_W-1:0] Z_MAX_Q16 = 32'd6553600;

	// Split point of the second multiplication.
	localparam int SPLIT_W = 20;
	localparam int OUT_SHIFT = 28;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} dpb_stage_en_t;

	// A zero size counts as one, and a size above the cap is held at the cap.
	function automatic logic [SIZE_CMP_W-1:0] eff_size(input logic [SIZE_REG_W-1:0] r,
			input logic [SIZE_CMP_W-1:0] cap);
		logic [SIZE_CMP_W-1:0] r_ext;
		r_ext = SIZE_CMP_W'(r);
		if (r_ext == '0)
			return SIZE_CMP_W'(1);
		else if (r_ext > cap)
			return cap;
		else
			return r_ext;
	endfunction

endpackage

FILE: rtl/dpb_pixel_counter.sv
// Raster column and row counters that wrap at the configured image size.
module dpb_pixel_counter #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	parameter int CW = $clog2(MAX_WIDTH),
	parameter int RW = $clog2(MAX_HEIGHT)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  logic [dpb_pkg::SIZE_REG_W-1:0]  image_width,
	input  logic [dpb_pkg::SIZE_REG_W-1:0]  image_height,
	output logic [CW-1:0]                   column,
	output logic [RW-1:0]                   row
);
	import dpb_pkg::*;

	logic [SIZE_CMP_W-1:0] w_eff;
	logic [SIZE_CMP_W-1:0] h_eff;
	logic [SIZE_CMP_W-1:0] col_inc;
	logic [SIZE_CMP_W-1:0] row_inc;
	logic [CW-1:0]         col_q;
	logic [RW-1:0]         row_q;

	assign w_eff   = eff_size(image_width, SIZE_CMP_W'(MAX_WIDTH));
	assign h_eff   = eff_size(image_height, SIZE_CMP_W'(MAX_HEIGHT));
	assign col_inc = SIZE_CMP_W'(col_q) + SIZE_CMP_W'(1);
	assign row_inc = SIZE_CMP_W'(row_q) + SIZE_CMP_W'(1);

	// A counter left beyond a shrunk size wraps on its next advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_inc >= w_eff) begin
				col_q <= '0;
				if (row_inc >= h_eff)
					row_q <= '0;
				else
					row_q <= RW'(row_inc);
			end else begin
				col_q <= CW'(col_inc);
			end
		end
	end

	assign column = col_q;
	assign row    = row_q;
endmodule

FILE: rtl/dpb_axis_proj.sv
// Pipelined projection of one axis: offset, two multiplications, floor shift and saturation.
module dpb_axis_proj #(
	parameter int PW = 12
) (
	input  logic                          clk,
	input  dpb_pkg::dpb_stage_en_t        en,
	input  logic [PW-1:0]                 pos_s1,
	input  logic [dpb_pkg::CENTRE_W-1:0]  centre,
	input  logic [dpb_pkg::Z_W-1:0]       z_s2,
	input  logic [dpb_pkg::COEF_W-1:0]    inv_focal,
	output logic [dpb_pkg::POINT_W-1:0]   point_s6
);
	import dpb_pkg::*;

	localparam int POSW = (PW + 4 > CENTRE_W) ? PW + 4 : CENTRE_W;
	localparam int PRODW = POSW + Z_W;
	localparam int HIW = PRODW - SPLIT_W;
	localparam int SUMW = PRODW + COEF_W;
	localparam int QW = SUMW - OUT_SHIFT;

	logic [POSW-1:0]          pos_q4;
	logic [POSW-1:0]          cen_ext;
	logic [POSW-1:0]          mag_s2;
	logic                     neg_s2;
	logic [PRODW-1:0]         prod_s3;
	logic                     neg_s3;
	logic [HIW+COEF_W-1:0]    phi_s4;
	logic [SPLIT_W+COEF_W-1:0] plo_s4;
	logic                     neg_s4;
	logic [SUMW-1:0]          sum;
	logic [QW-1:0]            q_s5;
	logic                     rem_s5;
	logic                     neg_s5;
	logic [QW:0]              q_up;
	logic [POINT_W-1:0]       point_nxt;

	assign pos_q4  = POSW'({pos_s1, 4'b0000});
	assign cen_ext = POSW'(centre);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			neg_s2 <= pos_q4 < cen_ext;
			mag_s2 <= (pos_q4 < cen_ext) ? cen_ext - pos_q4 : pos_q4 - cen_ext;
		end
		if (en.s3) begin
			prod_s3 <= PRODW'(mag_s2) * PRODW'(z_s2);
			neg_s3  <= neg_s2;
		end
		// The wide product is formed from two partial products.
		if (en.s4) begin
			phi_s4 <= (HIW+COEF_W)'(prod_s3[PRODW-1:SPLIT_W]) * (HIW+COEF_W)'(inv_focal);
			plo_s4 <= (SPLIT_W+COEF_W)'(prod_s3[SPLIT_W-1:0]) *
				(SPLIT_W+COEF_W)'(inv_focal);
			neg_s4 <= neg_s3;
		end
		if (en.s5) begin
			q_s5   <= sum[SUMW-1:OUT_SHIFT];
			rem_s5 <= |sum[OUT_SHIFT-1:0];
			neg_s5 <= neg_s4;
		end
		if (en.s6)
			point_s6 <= point_nxt;
	end

	assign sum  = {phi_s4, {SPLIT_W{1'b0}}} + SUMW'(plo_s4);
	assign q_up = (QW+1)'(q_s5) + (QW+1)'(rem_s5);

	// Negative results round towards minus infinity, hence the magnitude is rounded up.
	always_comb begin
		if (neg_s5) begin
			if (q_up >= (QW+1)'(33'h0_8000_0000))
				point_nxt = 32'h8000_0000;
			else
				point_nxt = POINT_W'(0) - q_up[POINT_W-1:0];
		end else begin
			if (q_s5 > QW'(32'h7FFF_FFFF))
				point_nxt = 32'h7FFF_FFFF;
			else
				point_nxt = q_s5[POINT_W-1:0];
		end
	end
endmodule

FILE: rtl/depth_pixel_backprojection.sv
// Top level of the depth pixel back-projection pipeline.
//
//   Channel   Direction  Handshake                Contents
//   s_axis    in         s_axis_tvalid/tready     one pixel: depth and colour bytes
//   m_axis    out        m_axis_tvalid/tready     one 3-D point with colour and position
//   cfg       in         cfg_valid/cfg_ready      register index and write data
//
// Six register stages, s1 to s6; a pixel accepted into s1 moves through s2 to s5 to the
// output register s6, from which its beat can leave, and one pixel is accepted every cycle
// unless a stall on m_axis_tready reaches back to the input. The depth of the two cascaded
// multiplications of each axis sets the stage count. Pixels outside the depth window are
// dropped at stage three and leave a bubble. Each stage holds its beat while the next is
// full and stalled, so an empty stage downstream still lets beats move up. Reset clears
// valid bits and counters and returns the configuration to its reset values.
module depth_pixel_backprojection #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [15:0] depth_raw, [23:16] blue, [31:24] green, [39:32] red
	input  logic [dpb_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [31:0] point_x, [63:32] point_y, [86:64] point_z, [94:87] out_blue,
	// [102:95] out_green, [110:103] out_red, [122:111] pixel_column,
	// [134:123] pixel_row, [135] zero
	output logic [dpb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dpb_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [dpb_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import dpb_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [SIZE_REG_W-1:0] image_width_q;
	logic [SIZE_REG_W-1:0] image_height_q;
	logic [COEF_W-1:0]     inv_scale_q;
	logic [CENTRE_W-1:0]   principal_x_q;
	logic [CENTRE_W-1:0]   principal_y_q;
	logic [COEF_W-1:0]     inv_focal_x_q;
	logic [COEF_W-1:0]     inv_focal_y_q;

	logic [CW-1:0] column;
	logic [RW-1:0] row;
	logic          accept;
	logic          en1;
	dpb_stage_en_t en;
	logic          keep;

	logic v1_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [DEPTH_W-1:0]  depth_s1;
	logic [CW-1:0]       col_s1;
	logic [RW-1:0]       row_s1;
	logic [3*COLOUR_W-1:0] bgr_s1, bgr_s2, bgr_s3, bgr_s4, bgr_s5, bgr_s6;
	logic [PIX_W-1:0]    colp_s2, colp_s3, colp_s4, colp_s5, colp_s6;
	logic [PIX_W-1:0]    rowp_s2, rowp_s3, rowp_s4, rowp_s5, rowp_s6;
	logic [Z_FULL_W-1:0] z_s2;
	logic [Z_W-1:0]      zo_s3, zo_s4, zo_s5, zo_s6;
	logic [DEPTH_W+COEF_W-1:0] z_prod;
	logic [POINT_W-1:0]  point_x_s6;
	logic [POINT_W-1:0]  point_y_s6;

	// Configuration port; writes beyond the register list are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RST_IMAGE_WIDTH;
			image_height_q <= RST_IMAGE_HEIGHT;
			inv_scale_q    <= RST_INV_SCALE;
			principal_x_q  <= RST_PRINCIPAL_X;
			principal_y_q  <= RST_PRINCIPAL_Y;
			inv_focal_x_q  <= RST_INV_FOCAL;
			inv_focal_y_q  <= RST_INV_FOCAL;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[SIZE_REG_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[SIZE_REG_W-1:0];
				REG_INV_SCALE:    inv_scale_q    <= cfg_data[COEF_W-1:0];
				REG_PRINCIPAL_X:  principal_x_q  <= cfg_data[CENTRE_W-1:0];
				REG_PRINCIPAL_Y:  principal_y_q  <= cfg_data[CENTRE_W-1:0];
				REG_INV_FOCAL_X:  inv_focal_x_q  <= cfg_data[COEF_W-1:0];
				REG_INV_FOCAL_Y:  inv_focal_y_q  <= cfg_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or when its beat moves on.
	assign en.s6 = !v_s6 || m_axis_tready;
	assign en.s5 = !v_s5 || en.s6;
	assign en.s4 = !v_s4 || en.s5;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en1   = !v1_s1 || en.s2;

	assign s_axis_tready = en1;
	assign accept        = s_axis_tvalid && en1;

	dpb_pixel_counter #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CW         (CW),
		.RW         (RW)
	) u_counter (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (accept),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.column       (column),
		.row          (row)
	);

	assign z_prod = (DEPTH_W+COEF_W)'(depth_s1) * (DEPTH_W+COEF_W)'(inv_scale_q);
	assign keep   = (z_s2 > Z_MIN_Q16) && (z_s2 <= Z_MAX_Q16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
		end else begin
			if (en1)
				v1_s1 <= s_axis_tvalid;
			if (en.s2)
				v_s2 <= v1_s1;
			if (en.s3)
				v_s3 <= v_s2 && keep;
			if (en.s4)
				v_s4 <= v_s3;
			if (en.s5)
				v_s5 <= v_s4;
			if (en.s6)
				v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			depth_s1 <= s_axis_tdata[DEPTH_W-1:0];
			bgr_s1   <= s_axis_tdata[DEPTH_W+3*COLOUR_W-1:DEPTH_W];
			col_s1   <= column;
			row_s1   <= row;
		end
		if (en.s2) begin
			z_s2    <= z_prod[DEPTH_W+COEF_W-1:8];
			bgr_s2  <= bgr_s1;
			colp_s2 <= PIX_W'(col_s1);
			rowp_s2 <= PIX_W'(row_s1);
		end
		if (en.s3) begin
			zo_s3   <= z_s2[Z_W-1:0];
			bgr_s3  <= bgr_s2;
			colp_s3 <= colp_s2;
			rowp_s3 <= rowp_s2;
		end
		if (en.s4) begin
			zo_s4   <= zo_s3;
			bgr_s4  <= bgr_s3;
			colp_s4 <= colp_s3;
			rowp_s4 <= rowp_s3;
		end
		if (en.s5) begin
			zo_s5   <= zo_s4;
			bgr_s5  <= bgr_s4;
			colp_s5 <= colp_s4;
			rowp_s5 <= rowp_s4;
		end
		if (en.s6) begin
			zo_s6   <= zo_s5;
			bgr_s6  <= bgr_s5;
			colp_s6 <= colp_s5;
			rowp_s6 <= rowp_s5;
		end
	end

	dpb_axis_proj #(
		.PW (CW)
	) u_proj_x (
		.clk       (clk),
		.en        (en),
		.pos_s1    (col_s1),
		.centre    (principal_x_q),
		.z_s2      (z_s2[Z_W-1:0]),
		.inv_focal (inv_focal_x_q),
		.point_s6  (point_x_s6)
	);

	dpb_axis_proj #(
		.PW (RW)
	) u_proj_y (
		.clk       (clk),
		.en        (en),
		.pos_s1    (row_s1),
		.centre    (principal_y_q),
		.z_s2      (z_s2[Z_W-1:0]),
		.inv_focal (inv_focal_y_q),
		.point_s6  (point_y_s6)
	);

	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = {1'b0, rowp_s6, colp_s6, bgr_s6, zo_s6, point_y_s6, point_x_s6};
endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the depth pixel back-projection block.
module tb_top;
	import dpb_pkg::*;

	localparam int FRAME_CAP     = 4096;
	localparam int PRODUCT_SHIFT = 28;
	localparam int DRAIN_SLACK   = 12;
	localparam int RANDOM_ITEMS  = 1650;
	localparam int CYCLE_LIMIT   = 400000;

	// Index past the end of the register file; a write there must change nothing.
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

	// Result beat, laid out as on m_axis_tdata (first member is the top bit).
	typedef struct packed {
		logic                pad;
		logic [PIX_W-1:0]    pixel_row;
		logic [PIX_W-1:0]    pixel_column;
		logic [COLOUR_W-1:0] out_red;
		logic [COLOUR_W-1:0] out_green;
		logic [COLOUR_W-1:0] out_blue;
		logic [Z_W-1:0]      point_z;
		logic [POINT_W-1:0]  point_y;
		logic [POINT_W-1:0]  point_x;
	} point_t;

	class point_scoreboard;
		logic [SIZE_REG_W-1:0] width_reg;
		logic [SIZE_REG_W-1:0] height_reg;
		logic [COEF_W-1:0]     depth_scale;
		logic [CENTRE_W-1:0]   centre_x;
		logic [CENTRE_W-1:0]   centre_y;
		logic [COEF_W-1:0]     focal_inv_x;
		logic [COEF_W-1:0]     focal_inv_y;
		logic [PIX_W-1:0]      col_cnt;
		logic [PIX_W-1:0]      row_cnt;
		point_t                expected_points[$];
		int                    errors;

		function void reset_state();
			width_reg   = 13'd640;
			height_reg  = 13'd480;
			depth_scale = 24'd16777;
			centre_x    = 16'd5112;
			centre_y    = 16'd3832;
			focal_inv_x = 24'd31957;
			focal_inv_y = 24'd31957;
			col_cnt     = '0;
			row_cnt     = '0;
			errors      = 0;
			expected_points.delete();
		endfunction

		function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_IMAGE_WIDTH: width_reg = value[SIZE_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_reg = value[SIZE_REG_W-1:0];
				REG_INV_SCALE: depth_scale = value;
				REG_PRINCIPAL_X: centre_x = value[CENTRE_W-1:0];
				REG_PRINCIPAL_Y: centre_y = value[CENTRE_W-1:0];
				REG_INV_FOCAL_X: focal_inv_x = value;
				REG_INV_FOCAL_Y: focal_inv_y = value;
				default: ;
			endcase
		endfunction

		function int size_limit(logic [SIZE_REG_W-1:0] r);
			if (r == '0)
				return 1;
			if (int'(r) > FRAME_CAP)
				return FRAME_CAP;
			return int'(r);
		endfunction

		// Q4 offset times Q16 depth times Q24 coefficient, floored to Q16 and clamped.
		function logic [POINT_W-1:0] back_project(logic [PIX_W-1:0] pos,
				logic [CENTRE_W-1:0] centre, logic [Z_W-1:0] z, logic [COEF_W-1:0] inv);
			logic [16:0] pos_q4;
			logic [16:0] centre_ext;
			logic        neg;
			logic [63:0] mag;
			logic [63:0] prod;
			logic [63:0] q;
			pos_q4 = {1'b0, pos, 4'b0000};
			centre_ext = {1'b0, centre};
			neg = pos_q4 < centre_ext;
			mag = neg ? 64'(centre_ext - pos_q4) : 64'(pos_q4 - centre_ext);
			prod = mag * 64'(z) * 64'(inv);
			q = prod >> PRODUCT_SHIFT;
			if (neg) begin
				if (prod[PRODUCT_SHIFT-1:0] != '0)
					q = q + 64'd1;
				if (q >= 64'h8000_0000)
					return 32'h8000_0000;
				return 32'(64'd0 - q);
			end
			if (q > 64'h7FFF_FFFF)
				return 32'h7FFF_FFFF;
			return q[31:0];
		endfunction

		function void note_pixel(logic [DEPTH_W-1:0] depth, logic [COLOUR_W-1:0] blue,
				logic [COLOUR_W-1:0] green, logic [COLOUR_W-1:0] red);
			logic [39:0] scaled;
			logic [31:0] z;
			point_t      p;
			int          w;
			int          h;
			scaled = 40'(depth) * 40'(depth_scale);
			z = scaled[39:8];
			if (z > Z_MIN_Q16 && z <= Z_MAX_Q16) begin
				p.pad          = 1'b0;
				p.point_x      = back_project(col_cnt, centre_x, z[Z_W-1:0], focal_inv_x);
				p.point_y      = back_project(row_cnt, centre_y, z[Z_W-1:0], focal_inv_y);
				p.point_z      = z[Z_W-1:0];
				p.out_blue     = blue;
				p.out_green    = green;
				p.out_red      = red;
				p.pixel_column = col_cnt;
				p.pixel_row    = row_cnt;
				expected_points.insert(expected_points.size(), p);
			end
			// Counters move on whether or not the pixel gave a point.
			w = size_limit(width_reg);
			h = size_limit(height_reg);
			if (int'(col_cnt) + 1 >= w) begin
				col_cnt = '0;
				if (int'(row_cnt) + 1 >= h)
					row_cnt = '0;
				else
					row_cnt = row_cnt + 1'b1;
			end else begin
				col_cnt = col_cnt + 1'b1;
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %h got %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_point(logic [OUT_TDATA_W-1:0] beat);
			point_t got;
			point_t want;
			got = point_t'(beat);
			if (expected_points.size() == 0) begin
				$display("%0t: point beat with no pixel pending, expected nothing got %h",
					$time, beat);
				errors++;
				return;
			end
			want = expected_points.pop_front();
			compare_field("point_x", want.point_x, got.point_x);
			compare_field("point_y", want.point_y, got.point_y);
			compare_field("point_z", 32'(want.point_z), 32'(got.point_z));
			compare_field("out_blue", 32'(want.out_blue), 32'(got.out_blue));
			compare_field("out_green", 32'(want.out_green), 32'(got.out_green));
			compare_field("out_red", 32'(want.out_red), 32'(got.out_red));
			compare_field("pixel_column", 32'(want.pixel_column), 32'(got.pixel_column));
			compare_field("pixel_row", 32'(want.pixel_row), 32'(got.pixel_row));
			compare_field("pad", 32'(want.pad), 32'(got.pad));
		endfunction

		function int pending();
			return expected_points.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// [15:0] depth_raw, [23:16] blue, [31:24] green, [39:32] red
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [31:0] point_x, [63:32] point_y, [86:64] point_z, [94:87] out_blue,
	// [102:95] out_green, [110:103] out_red, [122:111] pixel_column,
	// [134:123] pixel_row, [135] zero
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	point_scoreboard sb;

	logic [15:0] ready_pattern = '1;
	logic [3:0]  ready_step = '0;
	int          pattern_age = 0;

	depth_pixel_backprojection dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// The receiver steps through a 16-bit ready pattern that is redrawn now and then.
	always @(posedge clk) begin
		if (pattern_age == 0) begin
			pattern_age = $urandom_range(64, 400);
			case ($urandom_range(0, 3))
				0: ready_pattern = '1;
				1: ready_pattern = 16'h0001;
				default: ready_pattern = 16'($urandom) | 16'h0001;
			endcase
		end
		pattern_age--;
		ready_step++;
		m_axis_tready <= ready_pattern[ready_step];
	end

	// Handshake signals are stable at the falling edge, so a beat seen there is taken at
	// the next rising edge.
	always @(negedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_point(m_axis_tdata);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_top: FAIL");
		$finish;
	end

	task automatic send_pixel(logic [DEPTH_W-1:0] depth, logic [COLOUR_W-1:0] blue,
			logic [COLOUR_W-1:0] green, logic [COLOUR_W-1:0] red);
		s_axis_tdata <= {red, green, blue, depth};
		s_axis_tvalid <= 1'b1;
		@(negedge clk);
		while (!s_axis_tready)
			@(negedge clk);
		@(posedge clk);
		sb.note_pixel(depth, blue, green, red);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		sb.set_register(idx, value);
	endtask

	// Dropped pixels give no beat, so allow the pipeline to empty after the last point.
	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic configure(logic [SIZE_REG_W-1:0] w, logic [SIZE_REG_W-1:0] h,
			logic [COEF_W-1:0] scale, logic [CENTRE_W-1:0] cx, logic [CENTRE_W-1:0] cy,
			logic [COEF_W-1:0] fx, logic [COEF_W-1:0] fy);
		wait_drained();
		// Spare upper bits carry noise; the registers must keep only their own width.
		write_reg(REG_IMAGE_WIDTH, {11'($urandom), w});
		write_reg(REG_IMAGE_HEIGHT, {11'($urandom), h});
		write_reg(REG_INV_SCALE, scale);
		write_reg(REG_PRINCIPAL_X, {8'($urandom), cx});
		write_reg(REG_PRINCIPAL_Y, {8'($urandom), cy});
		write_reg(REG_INV_FOCAL_X, fx);
		write_reg(REG_INV_FOCAL_Y, fy);
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_SPARE, 24'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [SIZE_REG_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return 13'd0;
			1: return 13'd1;
			2: return 13'($urandom_range(2, 8));
			3: return 13'd4096;
			4: return 13'($urandom_range(4097, 8191));
			5: return 13'd640;
			default: return 13'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] pick_scale();
		case ($urandom_range(0, 9))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2: return 24'd256;
			3: return 24'd16777;
			4: return 24'd51200;
			default: return 24'($urandom_range(64, 60000));
		endcase
	endfunction

	function automatic logic [CENTRE_W-1:0] pick_centre();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] pick_focal();
		case ($urandom_range(0, 7))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2: return 24'd31957;
			3: return 24'($urandom);
			default: return 24'($urandom_range(1, 200000));
		endcase
	endfunction

	// Mostly aim the raw depth at a chosen metric depth so that most pixels land in
	// the window whatever the scale; the rest is raw noise.
	function automatic logic [DEPTH_W-1:0] pick_depth(logic [COEF_W-1:0] scale);
		longint target;
		longint d;
		if (scale == '0 || $urandom_range(0, 9) < 3)
			return 16'($urandom);
		case ($urandom_range(0, 9))
			0: target = $urandom_range(6549, 6558);
			1: target = $urandom_range(6553590, 6553610);
			default: target = $urandom_range(0, 6700000);
		endcase
		d = (target * 256) / longint'(scale);
		if (d > 65535)
			return 16'($urandom);
		return 16'(d);
	endfunction

	task automatic send_run(int count);
		int   left;
		int   burst;
		int   gap;
		logic no_gaps;
		no_gaps = ($urandom_range(0, 3) == 0);
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			if (burst > left)
				burst = left;
			repeat (burst)
				send_pixel(pick_depth(sb.depth_scale), 8'($urandom), 8'($urandom),
					8'($urandom));
			left -= burst;
			gap = no_gaps ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b0;
	endtask

	initial begin
		int phase;
		int count;
		int random_items;
		sb = new();
		sb.reset_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero depth, full depth, and the pixel that sits exactly on 0.1 m.
		send_pixel(16'd0, 8'h00, 8'hFF, 8'h00);
		send_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(16'd1000, 8'h00, 8'h00, 8'h00);
		send_pixel(16'd100, 8'hA5, 8'h5A, 8'h3C);
		send_pixel(16'd101, 8'h5A, 8'hA5, 8'hC3);
		s_axis_tvalid <= 1'b0;

		// Narrower frame than the current column, so the column wraps on its next advance.
		// With unit scale the lower depth limit falls between two raw values.
		configure(13'd3, 13'd2, 24'd256, 16'd0, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_pixel(16'd6553, 8'hFF, 8'h00, 8'hFF);
		send_pixel(16'd6554, 8'h00, 8'hFF, 8'h00);
		send_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
		s_axis_tvalid <= 1'b0;

		// Depth scale that puts raw 32768 exactly on 100 m; large y offsets saturate low.
		configure(13'd3, 13'd2, 24'd51200, 16'd0, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_pixel(16'd0, 8'h00, 8'h00, 8'h00);
		send_pixel(16'd32, 8'h11, 8'h22, 8'h33);
		send_pixel(16'd33, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(16'd32768, 8'h80, 8'h01, 8'h7F);
		send_pixel(16'd32769, 8'h01, 8'h80, 8'hFE);
		send_pixel(16'hFFFF, 8'hFF, 8'h00, 8'hFF);
		send_pixel(16'd1, 8'h00, 8'hFF, 8'h00);
		s_axis_tvalid <= 1'b0;

		// Zero width counts as one, an oversized height is capped, full-scale depth.
		configure(13'd0, 13'd8191, 24'hFFFFFF, 16'hFFFF, 16'd0, 24'd0, 24'($urandom));
		send_pixel(16'd1, 8'hFF, 8'h00, 8'h00);
		send_pixel(16'd100, 8'h00, 8'hFF, 8'h00);
		send_pixel(16'd101, 8'h00, 8'h00, 8'hFF);
		send_pixel(16'd0, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(16'hFFFF, 8'h00, 8'h00, 8'h00);
		s_axis_tvalid <= 1'b0;

		phase = 0;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (phase == 2 || phase == 3) begin
				// Long runs down one column and then along one row, so that both
				// coordinates climb far enough to saturate high.
				configure(phase == 2 ? 13'd1 : 13'd4096, 13'd4096, 24'd51200, 16'd0, 16'd0,
					24'hFFFFFF, 24'hFFFFFF);
				count = 400;
			end else begin
				configure(pick_size(), pick_size(), pick_scale(), pick_centre(),
					pick_centre(), pick_focal(), pick_focal());
				count = $urandom_range(40, 200);
			end
			send_run(count);
			random_items += count;
			phase++;
		end

		wait_drained();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
